/* sv/cspid_pkg.sv */
// Shared types, constants and helpers for the cascaded steering and speed PID.
package cspid_pkg;

  localparam int DUTY_MAX      = 10000;
  localparam int ENCODER_SCALE = 20;
  localparam int CAP_WIDE      = 16000;
  localparam int CAP_NARROW    = 2000;

  // Shared multiplier: unsigned 16-bit gain (as 17-bit signed) times 33-bit signed operand.
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  // Three products summed: two guard bits above the product.
  localparam int ACC_W   = PROD_W + 2;

  typedef enum logic [2:0] {
    REG_STEER_TARGET = 3'd0,
    REG_STEER_KP     = 3'd1,
    REG_STEER_KI     = 3'd2,
    REG_STEER_KD     = 3'd3,
    REG_SPEED_KP     = 3'd4,
    REG_SPEED_KI     = 3'd5,
    REG_SPEED_KD     = 3'd6,
    REG_BASE_SPEED   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] steer_error;
    logic signed [15:0] encoder_left;
    logic signed [15:0] encoder_right;
    logic               wide_limit;
  } item_t;

  typedef struct packed {
    logic        [13:0] duty_left;
    logic        [13:0] duty_right;
    logic signed [31:0] steer_correction;
    logic signed [31:0] target_left;
    logic signed [31:0] target_right;
  } result_t;

  // Saturate a wide signed value to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (v[ACC_W-1:31] == {(ACC_W-31){1'b0}}) || (v[ACC_W-1:31] == {(ACC_W-31){1'b1}});
    if (fits) begin
      return v[31:0];
    end else if (v[ACC_W-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

  // Clamp a PID output to the duty range 0..DUTY_MAX.
  function automatic logic [13:0] to_duty(input logic signed [31:0] v);
    logic [13:0] d;
    if (v <= 32'sd0) begin
      d = 14'd0;
    end else if (v >= 32'(DUTY_MAX)) begin
      d = 14'(DUTY_MAX);
    end else begin
      d = v[13:0];
    end
    return d;
  endfunction

endpackage

/* sv/cascade_steering_speed_pid.sv */
// Cascaded steering and speed PID: one shared multiplier under a small sequencer.
// One control tick per item beat. The outer steering PID turns steer_error into a
// correction; left target = base_speed - correction, right = base_speed + correction
// (both saturated to 32 bits). Each wheel then runs a speed PID against
// encoder * ENCODER_SCALE, with its error sum capped above at 16000 (wide_limit = 1)
// or 2000, and a duty clamped to 0..DUTY_MAX. Gains are unsigned Q8.8; each PID sums
// its three products exactly and floors the sum by 256. All nine products go through
// one 17 x 33 bit multiplier, one product per cycle, feeding a 52-bit accumulator.
// Steps: steering error; P, I and D multiplies and a finish for the steering loop;
// target, wheel error and wheel sum; multiplies and finish for the left, then the right
// wheel. item_ready is high only while the sequencer is idle, so a new item is taken
// only after the previous one has written its result. The result sits in an output
// register, so a new item is taken while the previous result waits; the sequencer only
// holds at the final step if the earlier result has still not been taken. cfg_ready is
// always high; configuration is meant to be written while the block is idle.
module cascade_steering_speed_pid (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  cspid_pkg::item_t      item_data,
  output logic                  result_valid,
  input  logic                  result_ready,
  output cspid_pkg::result_t    result_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cspid_pkg::cfg_reg_t   cfg_index,
  input  logic [15:0]           cfg_data
);

  localparam int ACC_W   = cspid_pkg::ACC_W;
  localparam int PROD_W  = cspid_pkg::PROD_W;
  localparam int MUL_A_W = cspid_pkg::MUL_A_W;
  localparam int MUL_B_W = cspid_pkg::MUL_B_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEER_ERR,
    ST_MUL,
    ST_FIN,
    ST_TARGET,
    ST_WHEEL_ERR,
    ST_WHEEL_SUM
  } state_t;

  typedef enum logic [1:0] {
    LOOP_STEER,
    LOOP_LEFT,
    LOOP_RIGHT
  } loop_t;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } term_t;

  state_t state;
  loop_t  loop;
  term_t  term;

  // Configuration registers
  logic signed [15:0] steer_target;
  logic [15:0]        steer_kp, steer_ki, steer_kd;
  logic [15:0]        speed_kp, speed_ki, speed_kd;
  logic [15:0]        base_speed;

  // Loop state
  logic signed [31:0] steer_integral;
  logic signed [16:0] steer_last_error;
  logic signed [31:0] left_error_sum, left_last_error;
  logic signed [31:0] right_error_sum, right_last_error;

  // Per-item working registers
  cspid_pkg::item_t   item;
  logic signed [17:0] steer_d;
  logic signed [31:0] corr, target_l, target_r;
  logic signed [31:0] err_l, err_r;
  logic signed [32:0] d_l, d_r;
  logic [13:0]        duty_l;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // Combinational datapath
  logic signed [16:0]        e_steer;
  logic signed [32:0]        integ_sum;
  logic signed [33:0]        scl_l, scl_r;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [15:0]               gain;
  logic signed [ACC_W-1:0]   fin_sum;
  logic signed [31:0]        fin_res;
  logic                      out_free;
  logic                      result_load;

  // Sum update: add, cap from above, saturate from below.
  function automatic logic signed [31:0] sum_cap(input logic signed [31:0] sum,
                                                 input logic signed [31:0] e,
                                                 input logic wide);
    logic signed [32:0] s;
    logic signed [32:0] cap;
    s   = 33'(sum) + 33'(e);
    cap = wide ? 33'(cspid_pkg::CAP_WIDE) : 33'(cspid_pkg::CAP_NARROW);
    if (s >= cap) begin
      return cap[31:0];
    end else if (s[32] != s[31]) begin
      return 32'sh8000_0000;
    end else begin
      return s[31:0];
    end
  endfunction

  assign item_ready  = (state == ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_free    = !result_valid || result_ready;
  // final step writes a new result beat this cycle
  assign result_load = (state == ST_FIN) && (loop == LOOP_RIGHT) && out_free;

  assign e_steer   = 17'(steer_target) - 17'(item.steer_error);
  assign integ_sum = 33'(steer_integral) + 33'(e_steer);
  assign scl_l     = 34'(item.encoder_left) * 34'(cspid_pkg::ENCODER_SCALE);
  assign scl_r     = 34'(item.encoder_right) * 34'(cspid_pkg::ENCODER_SCALE);

  // Operand select for the shared multiplier
  always_comb begin
    gain  = 16'd0;
    mul_b = '0;
    case (term)
      TERM_P: gain = (loop == LOOP_STEER) ? steer_kp : speed_kp;
      TERM_I: gain = (loop == LOOP_STEER) ? steer_ki : speed_ki;
      TERM_D: gain = (loop == LOOP_STEER) ? steer_kd : speed_kd;
      default: gain = 16'd0;
    endcase
    case (loop)
      LOOP_STEER: begin
        case (term)
          TERM_P:  mul_b = MUL_B_W'(steer_last_error);
          TERM_I:  mul_b = MUL_B_W'(steer_integral);
          TERM_D:  mul_b = MUL_B_W'(steer_d);
          default: mul_b = '0;
        endcase
      end
      LOOP_LEFT: begin
        case (term)
          TERM_P:  mul_b = MUL_B_W'(left_last_error);
          TERM_I:  mul_b = MUL_B_W'(left_error_sum);
          TERM_D:  mul_b = d_l;
          default: mul_b = '0;
        endcase
      end
      LOOP_RIGHT: begin
        case (term)
          TERM_P:  mul_b = MUL_B_W'(right_last_error);
          TERM_I:  mul_b = MUL_B_W'(right_error_sum);
          TERM_D:  mul_b = d_r;
          default: mul_b = '0;
        endcase
      end
      default: mul_b = '0;
    endcase
    mul_a = $signed({1'b0, gain});
  end

  // Last product folded in, floor by 256, saturate.
  assign fin_sum = acc + ACC_W'(prod);
  assign fin_res = cspid_pkg::sat32(fin_sum >>> 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      loop             <= LOOP_STEER;
      term             <= TERM_P;
      result_valid     <= 1'b0;
      steer_target     <= '0;
      steer_kp         <= '0;
      steer_ki         <= '0;
      steer_kd         <= '0;
      speed_kp         <= '0;
      speed_ki         <= '0;
      speed_kd         <= '0;
      base_speed       <= '0;
      steer_integral   <= '0;
      steer_last_error <= '0;
      left_error_sum   <= '0;
      left_last_error  <= '0;
      right_error_sum  <= '0;
      right_last_error <= '0;
    end else begin
      if (result_valid && result_ready && !result_load) begin
        result_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cspid_pkg::REG_STEER_TARGET: steer_target <= $signed(cfg_data);
          cspid_pkg::REG_STEER_KP:     steer_kp     <= cfg_data;
          cspid_pkg::REG_STEER_KI:     steer_ki     <= cfg_data;
          cspid_pkg::REG_STEER_KD:     steer_kd     <= cfg_data;
          cspid_pkg::REG_SPEED_KP:     speed_kp     <= cfg_data;
          cspid_pkg::REG_SPEED_KI:     speed_ki     <= cfg_data;
          cspid_pkg::REG_SPEED_KD:     speed_kd     <= cfg_data;
          cspid_pkg::REG_BASE_SPEED:   base_speed   <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            item  <= item_data;
            state <= ST_STEER_ERR;
          end
        end
        // Steering error, integral and derivative in one step
        ST_STEER_ERR: begin
          steer_integral   <= cspid_pkg::sat32(ACC_W'(integ_sum));
          steer_d          <= 18'(e_steer) - 18'(steer_last_error);
          steer_last_error <= e_steer;
          loop             <= LOOP_STEER;
          term             <= TERM_P;
          state            <= ST_MUL;
        end
        // One product per cycle; the previous product is accumulated
        ST_MUL: begin
          prod <= mul_a * mul_b;
          case (term)
            TERM_P: begin
              acc  <= '0;
              term <= TERM_I;
            end
            TERM_I: begin
              acc  <= ACC_W'(prod);
              term <= TERM_D;
            end
            TERM_D: begin
              acc   <= acc + ACC_W'(prod);
              state <= ST_FIN;
            end
            default: term <= TERM_P;
          endcase
        end
        ST_FIN: begin
          case (loop)
            LOOP_STEER: begin
              corr  <= fin_res;
              state <= ST_TARGET;
            end
            LOOP_LEFT: begin
              duty_l <= cspid_pkg::to_duty(fin_res);
              loop   <= LOOP_RIGHT;
              term   <= TERM_P;
              state  <= ST_MUL;
            end
            LOOP_RIGHT: begin
              // hold here only while the previous result is still unread
              if (out_free) begin
                result_data.duty_left        <= duty_l;
                result_data.duty_right       <= cspid_pkg::to_duty(fin_res);
                result_data.steer_correction <= corr;
                result_data.target_left      <= target_l;
                result_data.target_right     <= target_r;
                result_valid                 <= 1'b1;
                state                        <= ST_IDLE;
              end
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_TARGET: begin
          target_l <= cspid_pkg::sat32(ACC_W'($signed({1'b0, base_speed})) - ACC_W'(corr));
          target_r <= cspid_pkg::sat32(ACC_W'($signed({1'b0, base_speed})) + ACC_W'(corr));
          state    <= ST_WHEEL_ERR;
        end
        ST_WHEEL_ERR: begin
          err_l <= cspid_pkg::sat32(ACC_W'(target_l) - ACC_W'(scl_l));
          err_r <= cspid_pkg::sat32(ACC_W'(target_r) - ACC_W'(scl_r));
          state <= ST_WHEEL_SUM;
        end
        ST_WHEEL_SUM: begin
          left_error_sum   <= sum_cap(left_error_sum, err_l, item.wide_limit);
          right_error_sum  <= sum_cap(right_error_sum, err_r, item.wide_limit);
          d_l              <= 33'(err_l) - 33'(left_last_error);
          d_r              <= 33'(err_r) - 33'(right_last_error);
          left_last_error  <= err_l;
          right_last_error <= err_r;
          loop             <= LOOP_LEFT;
          term             <= TERM_P;
          state            <= ST_MUL;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Duties stay inside the clamp range.
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_data.duty_left <= 14'(cspid_pkg::DUTY_MAX))
                  && (result_data.duty_right <= 14'(cspid_pkg::DUTY_MAX)))
    else $error("duty out of range");

  // An accepted item keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item taken while busy");

  // Speed error sums never pass the wide cap.
  a_sum_cap: assert property (@(posedge clk) disable iff (rst)
    (left_error_sum <= 32'(cspid_pkg::CAP_WIDE))
    && (right_error_sum <= 32'(cspid_pkg::CAP_WIDE)))
    else $error("error sum above cap");

  // A pending unread result stalls the final step instead of being overwritten.
  a_hold_final: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && loop == LOOP_RIGHT && result_valid && !result_ready)
    |=> (state == ST_FIN) && result_valid)
    else $error("result overwritten");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the cascaded steering and speed PID controller.
`timescale 1ns / 1ps

module tb;

  // Once the last expected result has come, wait longer than an item takes from
  // its accepting edge to its result beat.
  localparam int TAIL_CYCLES = 24;
  // Cycles without any beat on any channel before the run is declared hung.
  localparam int STALL_LIMIT = 1000;

  localparam longint S32_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32_LO = -S32_HI - 1;

  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 260;
  // Enough max-error ticks at full gains to push the correction onto its
  // upper rail and overflow the right target.
  localparam int WINDUP_ITEMS     = 150;

  // Directed ticks: field extremes, alternating bit patterns, odd negative
  // sums (floor shift), duties below zero / in range / above the ceiling,
  // and the wide and narrow error sum caps.
  localparam int N_DIRECTED = 16;
  localparam cspid_pkg::item_t DIRECTED [N_DIRECTED] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b0},
    '{16'sd0,      16'sd250,    16'sd250,    1'b1},
    '{16'sh8000,   16'sd0,      16'sd0,      1'b0},
    '{16'sh7FFF,   16'sd0,      16'sd0,      1'b1},
    '{16'sd0,      16'sh7FFF,   16'sh8000,   1'b0},
    '{16'sd0,      16'sh8000,   16'sh7FFF,   1'b1},
    '{16'sd1,      16'sd249,    16'sd251,    1'b0},
    '{16'shFFFF,   16'sd251,    16'sd249,    1'b1},
    '{16'sd0,      16'sd240,    16'sd260,    1'b0},
    '{16'sd100,    16'sd255,    16'sd245,    1'b1},
    '{16'shFF9C,   16'sd245,    16'sd255,    1'b0},
    '{16'sh5555,   16'shAAAA,   16'sh5555,   1'b1},
    '{16'shAAAA,   16'sh5555,   16'shAAAA,   1'b0},
    '{16'shFFFF,   16'sd0,      16'shFFFF,   1'b1},
    '{16'sd0,      16'shF830,   16'shF830,   1'b1},
    '{16'sd0,      16'shF830,   16'shF830,   1'b0}
  };

  // ---------------------------------------------------------------------------
  // Scoreboard: a bit-true model of the controller plus the queue of duties,
  // corrections and targets it has predicted and not yet seen come out.
  // ---------------------------------------------------------------------------
  class pid_scoreboard;
    cspid_pkg::result_t expected_q[$];
    int unsigned        errors  = 0;
    int unsigned        ticks   = 0;
    int unsigned        checked = 0;

    // Register copies, all zero out of reset.
    logic signed [15:0] steer_target = '0;
    logic        [15:0] steer_kp = '0, steer_ki = '0, steer_kd = '0;
    logic        [15:0] speed_kp = '0, speed_ki = '0, speed_kd = '0;
    logic        [15:0] base_speed = '0;

    // Loop state, kept wide so saturation is explicit.
    longint steer_integral = 0, steer_last = 0;
    longint left_sum = 0, left_last = 0, right_sum = 0, right_last = 0;

    function longint clip32(longint v);
      if (v > S32_HI) return S32_HI;
      if (v < S32_LO) return S32_LO;
      return v;
    endfunction

    function logic [13:0] duty_of(longint v);
      if (v <= 0) return '0;
      if (v >= cspid_pkg::DUTY_MAX) return 14'(cspid_pkg::DUTY_MAX);
      return v[13:0];
    endfunction

    function void note_config(cspid_pkg::cfg_reg_t idx, logic [15:0] v);
      case (idx)
        cspid_pkg::REG_STEER_TARGET: steer_target = v;
        cspid_pkg::REG_STEER_KP:     steer_kp     = v;
        cspid_pkg::REG_STEER_KI:     steer_ki     = v;
        cspid_pkg::REG_STEER_KD:     steer_kd     = v;
        cspid_pkg::REG_SPEED_KP:     speed_kp     = v;
        cspid_pkg::REG_SPEED_KI:     speed_ki     = v;
        cspid_pkg::REG_SPEED_KD:     speed_kd     = v;
        cspid_pkg::REG_BASE_SPEED:   base_speed   = v;
        default: ;
      endcase
    endfunction

    // Inner speed loop for one wheel; sum and last are that wheel's state.
    function longint wheel_pid(longint target, logic signed [15:0] enc, bit wide,
                               inout longint sum, inout longint last);
      longint cap, e, s, acc;
      cap = wide ? cspid_pkg::CAP_WIDE : cspid_pkg::CAP_NARROW;
      e = clip32(target - longint'(enc) * cspid_pkg::ENCODER_SCALE);
      s = sum + e;
      if (s >= cap) s = cap;   // capped above only
      s = clip32(s);           // lower side just saturates
      sum = s;
      acc = longint'(speed_kp) * e + longint'(speed_ki) * s
          + longint'(speed_kd) * (e - last);
      last = e;
      return clip32(acc >>> 8);  // floor, also for negative sums
    endfunction

    function void note_item(cspid_pkg::item_t it);
      longint  e, acc, corr, tl, tr, ol, orr;
      cspid_pkg::result_t r;
      e = longint'(steer_target) - longint'($signed(it.steer_error));
      steer_integral = clip32(steer_integral + e);
      acc = longint'(steer_kp) * e + longint'(steer_ki) * steer_integral
          + longint'(steer_kd) * (e - steer_last);
      steer_last = e;
      corr = clip32(acc >>> 8);
      tl = clip32(longint'(base_speed) - corr);
      tr = clip32(longint'(base_speed) + corr);
      ol  = wheel_pid(tl, it.encoder_left,  it.wide_limit, left_sum,  left_last);
      orr = wheel_pid(tr, it.encoder_right, it.wide_limit, right_sum, right_last);
      r.duty_left        = duty_of(ol);
      r.duty_right       = duty_of(orr);
      r.steer_correction = corr[31:0];
      r.target_left      = tl[31:0];
      r.target_right     = tr[31:0];
      expected_q.push_back(r);
      ticks++;
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d (tick %0d)", what, got, want,
               checked);
      errors++;
    endtask

    task check_result(cspid_pkg::result_t got);
      cspid_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report("result beat with nothing pending", longint'($signed(got.steer_correction)), 0);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.duty_left !== want.duty_left)
        report("duty_left", got.duty_left, want.duty_left);
      if (got.duty_right !== want.duty_right)
        report("duty_right", got.duty_right, want.duty_right);
      if (got.steer_correction !== want.steer_correction)
        report("steer_correction", longint'($signed(got.steer_correction)),
               longint'($signed(want.steer_correction)));
      if (got.target_left !== want.target_left)
        report("target_left", longint'($signed(got.target_left)),
               longint'($signed(want.target_left)));
      if (got.target_right !== want.target_right)
        report("target_right", longint'($signed(got.target_right)),
               longint'($signed(want.target_right)));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, DUT and its inputs (all known from time zero).
  // ---------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  cspid_pkg::item_t    item_data = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  cspid_pkg::result_t  result_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cspid_pkg::cfg_reg_t cfg_index = cspid_pkg::REG_STEER_TARGET;
  logic [15:0]         cfg_data = '0;

  pid_scoreboard sb = new;

  // Idle percentage for the current phase; the sink uses a fifth of it per cycle.
  int gap_pct = 25;
  int settings_loaded = 0;
  int quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cascade_steering_speed_pid i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure bursts of random length.
  // ---------------------------------------------------------------------------
  int ready_hold = 0;

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      if (ready_hold == 0) result_ready <= 1'b1;
    end else if (gap_pct != 0 && $urandom_range(499) < gap_pct) begin
      result_ready <= 1'b0;
      ready_hold = $urandom_range(12, 1);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples every channel at the edge (pre-update values), feeds the
  // scoreboard and runs the hang watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    bit beat;
    beat = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.note_config(cfg_index, cfg_data);
        beat = 1'b1;
      end
      if (item_valid && item_ready) begin
        sb.note_item(item_data);
        beat = 1'b1;
      end
      if (result_valid && result_ready) begin
        sb.check_result(result_data);
        beat = 1'b1;
      end
      if (beat) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results still pending",
                 STALL_LIMIT, sb.expected_q.size());
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks.
  // ---------------------------------------------------------------------------
  task automatic write_reg(cspid_pkg::cfg_reg_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes every register back to back; only called with the block idle.
  task automatic load_regs(logic [15:0] tgt, logic [15:0] s_kp, logic [15:0] s_ki,
                           logic [15:0] s_kd, logic [15:0] v_kp, logic [15:0] v_ki,
                           logic [15:0] v_kd, logic [15:0] base);
    write_reg(cspid_pkg::REG_STEER_TARGET, tgt);
    write_reg(cspid_pkg::REG_STEER_KP, s_kp);
    write_reg(cspid_pkg::REG_STEER_KI, s_ki);
    write_reg(cspid_pkg::REG_STEER_KD, s_kd);
    write_reg(cspid_pkg::REG_SPEED_KP, v_kp);
    write_reg(cspid_pkg::REG_SPEED_KI, v_ki);
    write_reg(cspid_pkg::REG_SPEED_KD, v_kd);
    write_reg(cspid_pkg::REG_BASE_SPEED, base);
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // One item beat, optionally preceded by an idle burst. Valid stays high
  // between back-to-back items; only the payload changes.
  task automatic send_item(cspid_pkg::item_t it);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_data  <= it;
    do @(posedge clk); while (!item_ready);
  endtask

  // Wait for all pending results, then let the sequencer run dry.
  task automatic settle();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Mostly plausible ticks (small steering error, encoders near base/20),
  // the rest full-range noise. The overflow run drives the error to its
  // positive end so the integral winds down hard.
  function automatic cspid_pkg::item_t make_item(bit overflow_run);
    cspid_pkg::item_t it;
    it.wide_limit = 1'($urandom);
    if (overflow_run) begin
      it.steer_error   = 16'($urandom_range(32767, 28000));
      it.encoder_left  = 16'($urandom);
      it.encoder_right = 16'($urandom);
    end else if ($urandom_range(99) < 70) begin
      it.steer_error   = 16'(int'($urandom_range(4000)) - 2000);
      it.encoder_left  = 16'(int'($urandom_range(500)) - 50);
      it.encoder_right = 16'(int'($urandom_range(500)) - 50);
    end else begin
      it.steer_error   = 16'($urandom);
      it.encoder_left  = 16'($urandom);
      it.encoder_right = 16'($urandom);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    cspid_pkg::item_t it;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks under unity-ish gains and a mid base speed.
    load_regs(16'd0, 16'd256, 16'd32, 16'd128, 16'd256, 16'd64, 16'd32, 16'd5000);
    for (int i = 0; i < N_DIRECTED; i++) send_item(DIRECTED[i]);
    item_valid <= 1'b0;
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin  // plausible tuning
          gap_pct = 30;
          load_regs(16'(int'($urandom_range(200)) - 100), 16'($urandom_range(1024)),
                    16'($urandom_range(64)), 16'($urandom_range(512)),
                    16'($urandom_range(768)), 16'($urandom_range(128)),
                    16'($urandom_range(256)), 16'($urandom_range(8000)));
        end
        1: begin  // every register at its top
          gap_pct = 10;
          load_regs(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF);
        end
        2: begin  // gains off, most negative target
          gap_pct = 50;
          load_regs(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'h0000, 16'h0000);
        end
        3: begin  // anything goes, no idling
          gap_pct = 0;
          load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
        4: begin
          gap_pct = 20;
          load_regs(16'(int'($urandom_range(200)) - 100), 16'($urandom_range(1024)),
                    16'($urandom_range(64)), 16'($urandom_range(512)),
                    16'($urandom_range(768)), 16'($urandom_range(128)),
                    16'($urandom_range(256)), 16'($urandom_range(8000)));
        end
        default: begin  // drive the correction to its negative rail
          gap_pct = 30;
          load_regs(16'h8000, 16'($urandom), 16'hFFFF, 16'($urandom),
                    16'($urandom_range(1024)), 16'($urandom_range(256)),
                    16'($urandom_range(512)), 16'($urandom));
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(make_item(phase == RANDOM_PHASES - 1));
      item_valid <= 1'b0;
      settle();
    end

    // Final stretch at full rate on both sides: maximum positive steering
    // error until the correction sits on its upper rail and the right target
    // overflows.
    gap_pct = 0;
    load_regs(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'($urandom_range(1024)),
              16'($urandom_range(256)), 16'($urandom_range(512)), 16'($urandom));
    for (int n = 0; n < WINDUP_ITEMS; n++) begin
      it.steer_error   = 16'sh8000;
      it.encoder_left  = 16'($urandom);
      it.encoder_right = 16'($urandom);
      it.wide_limit    = 1'($urandom);
      send_item(it);
    end
    item_valid <= 1'b0;
    settle();

    $display("covered %0d ticks over %0d register settings, %0d results compared",
             sb.ticks, settings_loaded, sb.checked);
    $display("incl. directed extremes, saturation of both targets and the correction");
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
